// ===== rtl/core/pci_capability_walker_top_defines.svh =====
// ----------------------------------------------------------------------------
// pci capability walker assertion macros
// shared property wrappers, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef PCI_CAPABILITY_WALKER_TOP_DEFINES_SVH
`define PCI_CAPABILITY_WALKER_TOP_DEFINES_SVH

// same-cycle implication
`define PCW_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcw_pkg.sv =====
// ----------------------------------------------------------------------------
// pcw_pkg
// types and constants shared by the pci capability walker modules
// ----------------------------------------------------------------------------
package pcw_pkg;

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // result kinds
  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // search outcomes
  typedef enum logic [2:0] {
    OUTCOME_FOUND     = 3'd0,
    OUTCOME_ABSENT    = 3'd1,
    OUTCOME_NO_LIST   = 3'd2,
    OUTCOME_LIST_END  = 3'd3,
    OUTCOME_HOP_LIMIT = 3'd4
  } outcome_t;

  // config space layout
  localparam logic [7:0]  STATUS_OFFSET  = 8'h04;
  localparam logic [7:0]  CAP_PTR_OFFSET = 8'h34;
  localparam logic [7:0]  PTR_MASK       = 8'hFC;
  localparam logic [7:0]  LIST_FLOOR     = 8'h40;
  localparam logic [15:0] STATUS_ABSENT  = 16'hFFFF;
  localparam int          STATUS_CAP_BIT = 4;

  // hop counter width
  localparam int HOP_W = 6;

  typedef struct packed {
    logic        cmd;
    logic [15:0] segment;
    logic [7:0]  bus_number;
    logic [4:0]  device_number;
    logic [2:0]  function_number;
    logic [7:0]  wanted_id;
    logic [31:0] read_data;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] req_segment;
    logic [7:0]  req_bus;
    logic [4:0]  req_device;
    logic [2:0]  req_function;
    logic [7:0]  req_offset;
    logic [7:0]  found_offset;
    outcome_t    outcome;
  } result_t;

endpackage

// ===== rtl/core/pcw_step.sv =====
// ----------------------------------------------------------------------------
// pcw_step
// walk state and the per-transaction decision: one item in, at most one result
// ----------------------------------------------------------------------------
module pcw_step #(
  parameter int MAX_HOPS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  pcw_pkg::item_t   item,
  output logic             emit,
  output pcw_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STATUS,
    PH_HEAD,
    PH_ENTRY
  } phase_t;

  localparam logic [pcw_pkg::HOP_W-1:0] HOP_LIMIT = pcw_pkg::HOP_W'(MAX_HOPS);

  phase_t                    phase, phase_next;
  logic [15:0]               target_segment, target_segment_next;
  logic [7:0]                target_bus, target_bus_next;
  logic [4:0]                target_device, target_device_next;
  logic [2:0]                target_function, target_function_next;
  logic [7:0]                sought_id, sought_id_next;
  logic [7:0]                entry_offset, entry_offset_next;
  logic [pcw_pkg::HOP_W-1:0] hop_count, hop_count_next;

  logic                      do_follow;
  logic [7:0]                follow_raw;
  logic [7:0]                follow_off;
  logic [15:0]               status;
  logic [pcw_pkg::HOP_W-1:0] hop_inc;

  assign status     = item.read_data[31:16];
  assign hop_inc    = hop_count + pcw_pkg::HOP_W'(1);
  assign follow_off = follow_raw & pcw_pkg::PTR_MASK;

  // decision for the item in the input register
  always_comb begin
    phase_next           = phase;
    target_segment_next  = target_segment;
    target_bus_next      = target_bus;
    target_device_next   = target_device;
    target_function_next = target_function;
    sought_id_next       = sought_id;
    entry_offset_next    = entry_offset;
    hop_count_next       = hop_count;
    do_follow            = 1'b0;
    follow_raw           = item.read_data[7:0];
    emit                 = 1'b0;
    res                  = '0;
    res.kind             = pcw_pkg::KIND_REQ;
    res.outcome          = pcw_pkg::OUTCOME_FOUND;

    if (item.cmd == pcw_pkg::CMD_START) begin
      // latch target and ask for the status dword
      target_segment_next  = item.segment;
      target_bus_next      = item.bus_number;
      target_device_next   = item.device_number;
      target_function_next = item.function_number;
      sought_id_next       = item.wanted_id;
      entry_offset_next    = '0;
      hop_count_next       = '0;
      phase_next           = PH_STATUS;
      emit                 = 1'b1;
      res.req_segment      = item.segment;
      res.req_bus          = item.bus_number;
      res.req_device       = item.device_number;
      res.req_function     = item.function_number;
      res.req_offset       = pcw_pkg::STATUS_OFFSET;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          // stray read data, dropped
        end
        PH_STATUS: begin
          emit = 1'b1;
          if (status == pcw_pkg::STATUS_ABSENT) begin
            res.kind    = pcw_pkg::KIND_DONE;
            res.outcome = pcw_pkg::OUTCOME_ABSENT;
            phase_next  = PH_IDLE;
          end else if (!status[pcw_pkg::STATUS_CAP_BIT]) begin
            res.kind    = pcw_pkg::KIND_DONE;
            res.outcome = pcw_pkg::OUTCOME_NO_LIST;
            phase_next  = PH_IDLE;
          end else begin
            phase_next       = PH_HEAD;
            res.req_segment  = target_segment;
            res.req_bus      = target_bus;
            res.req_device   = target_device;
            res.req_function = target_function;
            res.req_offset   = pcw_pkg::CAP_PTR_OFFSET;
          end
        end
        PH_HEAD: begin
          do_follow  = 1'b1;
          follow_raw = item.read_data[7:0];
        end
        PH_ENTRY: begin
          if (item.read_data[7:0] == sought_id) begin
            emit             = 1'b1;
            res.kind         = pcw_pkg::KIND_DONE;
            res.found_offset = entry_offset;
            res.outcome      = pcw_pkg::OUTCOME_FOUND;
            phase_next       = PH_IDLE;
          end else begin
            hop_count_next = hop_inc;
            if (hop_inc >= HOP_LIMIT) begin
              emit        = 1'b1;
              res.kind    = pcw_pkg::KIND_DONE;
              res.outcome = pcw_pkg::OUTCOME_HOP_LIMIT;
              phase_next  = PH_IDLE;
            end else begin
              do_follow  = 1'b1;
              follow_raw = item.read_data[15:8];
            end
          end
        end
        default: begin
        end
      endcase
    end

    // follow a list pointer: end of list or request the entry
    if (do_follow) begin
      emit = 1'b1;
      if (follow_off < pcw_pkg::LIST_FLOOR) begin
        res.kind    = pcw_pkg::KIND_DONE;
        res.outcome = pcw_pkg::OUTCOME_LIST_END;
        phase_next  = PH_IDLE;
      end else begin
        entry_offset_next = follow_off;
        phase_next        = PH_ENTRY;
        res.req_segment   = target_segment;
        res.req_bus       = target_bus;
        res.req_device    = target_device;
        res.req_function  = target_function;
        res.req_offset    = follow_off;
      end
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      target_segment  <= '0;
      target_bus      <= '0;
      target_device   <= '0;
      target_function <= '0;
      sought_id       <= '0;
      entry_offset    <= '0;
      hop_count       <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      target_segment  <= target_segment_next;
      target_bus      <= target_bus_next;
      target_device   <= target_device_next;
      target_function <= target_function_next;
      sought_id       <= sought_id_next;
      entry_offset    <= entry_offset_next;
      hop_count       <= hop_count_next;
    end
  end

endmodule

// ===== rtl/core/pci_capability_walker_top.sv =====
// ----------------------------------------------------------------------------
// pci_capability_walker_top
// searches a pci function's capability list, driven by read transactions
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid / in_ready | cmd, segment .. wanted_id, read_data
//  out     | out_valid/out_ready | kind, req_* address, found_offset, outcome
//
//  one transaction per cycle sustained while out_ready holds: input register,
//  one decision step, result register; out_valid rises when res_q is loaded.
//  synchronous reset puts the walk in idle; there is no clearing pass
//  a held result does not stop the input side until the input register also
//  holds an item that makes a result; items that make none drain regardless
// ----------------------------------------------------------------------------
`include "pci_capability_walker_top_defines.svh"

module pci_capability_walker_top #(
  parameter int MAX_HOPS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] segment,
  input  logic [7:0]  bus_number,
  input  logic [4:0]  device_number,
  input  logic [2:0]  function_number,
  input  logic [7:0]  wanted_id,
  input  logic [31:0] read_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [15:0] req_segment,
  output logic [7:0]  req_bus,
  output logic [4:0]  req_device,
  output logic [2:0]  req_function,
  output logic [7:0]  req_offset,
  output logic [7:0]  found_offset,
  output logic [2:0]  outcome
);

  logic             item_valid;
  pcw_pkg::item_t   item_q;
  logic             drain;
  logic             emit;
  pcw_pkg::result_t res;
  pcw_pkg::result_t res_q;

  logic             item_stall;
  logic             out_req;
  logic             out_done;
  logic             req_fields_clear;
  logic             done_fields_clear;
  logic             req_offset_ok;

  // input register drains when the result slot can take what it makes
  assign drain    = item_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !item_valid || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (drain) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.cmd             <= cmd;
      item_q.segment         <= segment;
      item_q.bus_number      <= bus_number;
      item_q.device_number   <= device_number;
      item_q.function_number <= function_number;
      item_q.wanted_id       <= wanted_id;
      item_q.read_data       <= read_data;
    end
  end

  // decision and walk state
  pcw_step #(
    .MAX_HOPS(MAX_HOPS)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (drain),
    .item (item_q),
    .emit (emit),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && emit) begin
      res_q <= res;
    end
  end

  assign kind         = res_q.kind;
  assign req_segment  = res_q.req_segment;
  assign req_bus      = res_q.req_bus;
  assign req_device   = res_q.req_device;
  assign req_function = res_q.req_function;
  assign req_offset   = res_q.req_offset;
  assign found_offset = res_q.found_offset;
  assign outcome      = res_q.outcome;

  // terms for the checks below
  assign item_stall        = item_valid && !drain;
  assign out_req           = out_valid && kind == pcw_pkg::KIND_REQ;
  assign out_done          = out_valid && kind == pcw_pkg::KIND_DONE;
  assign req_fields_clear  = found_offset == 8'h00 && outcome == pcw_pkg::OUTCOME_FOUND;
  assign done_fields_clear = req_offset == 8'h00 && req_segment == 16'h0000;
  assign req_offset_ok     = req_offset[1:0] == 2'b00 &&
                             (req_offset == pcw_pkg::STATUS_OFFSET ||
                              req_offset == pcw_pkg::CAP_PTR_OFFSET ||
                              req_offset >= pcw_pkg::LIST_FLOOR);

  // assertions
  `PCW_ASSERT_NEXT(a_item_held, item_stall, item_valid && $stable(item_q), "item lost in stall")
  `PCW_ASSERT_HOLDS(a_req_clean, out_req, req_fields_clear, "request carries finish fields")
  `PCW_ASSERT_HOLDS(a_done_clean, out_done, done_fields_clear, "finish carries request fields")
  `PCW_ASSERT_HOLDS(a_req_offset, out_req, req_offset_ok, "bad request offset")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pci capability walker testbench
// drives start and read-data transactions that mimic a function's config
// space, predicts every read request and search outcome, and checks the
// results in order under four sender/receiver idling mixes
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD   = 10;
  localparam int HOP_LIMIT    = 48;
  localparam int PHASE_ITEMS  = 338;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 40;

  // what the walker is waiting for next
  typedef enum logic [1:0] {
    SEEK_IDLE   = 2'd0,
    SEEK_STATUS = 2'd1,
    SEEK_HEAD   = 2'd2,
    SEEK_ENTRY  = 2'd3
  } seek_phase_t;

  // shapes of a generated search
  typedef enum int {
    WALK_ABSENT,
    WALK_NO_LIST,
    WALK_EMPTY,
    WALK_FOUND,
    WALK_LIST_END,
    WALK_HOP_LIMIT
  } walk_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [15:0] segment = '0;
  logic [7:0]  bus_number = '0;
  logic [4:0]  device_number = '0;
  logic [2:0]  function_number = '0;
  logic [7:0]  wanted_id = '0;
  logic [31:0] read_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [15:0] req_segment;
  logic [7:0]  req_bus;
  logic [4:0]  req_device;
  logic [2:0]  req_function;
  logic [7:0]  req_offset;
  logic [7:0]  found_offset;
  logic [2:0]  outcome;

  pcw_pkg::item_t   stim_queue[$];
  pcw_pkg::result_t walk_results_due[$];
  pcw_pkg::item_t   next_item;
  pcw_pkg::result_t seen;
  pcw_pkg::result_t want;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int items_made     = 0;
  int walks_made     = 0;
  int cycle_count    = 0;

  // predictor copy of the walker state
  seek_phase_t seek_phase  = SEEK_IDLE;
  logic [15:0] tgt_segment = '0;
  logic [7:0]  tgt_bus     = '0;
  logic [4:0]  tgt_device  = '0;
  logic [2:0]  tgt_function = '0;
  logic [7:0]  sought_id   = '0;
  logic [7:0]  entry_off   = '0;
  logic [5:0]  hops        = '0;

  pci_capability_walker_top #(
    .MAX_HOPS(HOP_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .segment(segment),
    .bus_number(bus_number),
    .device_number(device_number),
    .function_number(function_number),
    .wanted_id(wanted_id),
    .read_data(read_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .req_segment(req_segment),
    .req_bus(req_bus),
    .req_device(req_device),
    .req_function(req_function),
    .req_offset(req_offset),
    .found_offset(found_offset),
    .outcome(outcome)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic pcw_pkg::result_t read_req(logic [7:0] off);
    pcw_pkg::result_t r;
    r = '0;
    r.kind = pcw_pkg::KIND_REQ;
    r.req_segment = tgt_segment;
    r.req_bus = tgt_bus;
    r.req_device = tgt_device;
    r.req_function = tgt_function;
    r.req_offset = off & pcw_pkg::PTR_MASK;
    return r;
  endfunction

  function automatic pcw_pkg::result_t walk_done(logic [7:0] found,
                                                 pcw_pkg::outcome_t why);
    pcw_pkg::result_t r;
    r = '0;
    r.kind = pcw_pkg::KIND_DONE;
    r.found_offset = found;
    r.outcome = why;
    seek_phase = SEEK_IDLE;
    return r;
  endfunction

  // follow a raw pointer: either the list ends or the entry is requested
  function automatic pcw_pkg::result_t chase(logic [7:0] raw);
    logic [7:0] off;
    off = raw & pcw_pkg::PTR_MASK;
    if (off < pcw_pkg::LIST_FLOOR) begin
      return walk_done(8'h00, pcw_pkg::OUTCOME_LIST_END);
    end
    entry_off = off;
    seek_phase = SEEK_ENTRY;
    return read_req(off);
  endfunction

  task automatic walk_step(input pcw_pkg::item_t it);
    pcw_pkg::result_t r;
    logic [15:0]      status;
    logic             emits;
    r = '0;
    emits = 1'b1;
    if (it.cmd == pcw_pkg::CMD_START) begin
      tgt_segment = it.segment;
      tgt_bus = it.bus_number;
      tgt_device = it.device_number;
      tgt_function = it.function_number;
      sought_id = it.wanted_id;
      entry_off = '0;
      hops = '0;
      seek_phase = SEEK_STATUS;
      r = read_req(pcw_pkg::STATUS_OFFSET);
    end else begin
      case (seek_phase)
        SEEK_STATUS: begin
          status = it.read_data[31:16];
          if (status == pcw_pkg::STATUS_ABSENT) begin
            r = walk_done(8'h00, pcw_pkg::OUTCOME_ABSENT);
          end else if (!status[pcw_pkg::STATUS_CAP_BIT]) begin
            r = walk_done(8'h00, pcw_pkg::OUTCOME_NO_LIST);
          end else begin
            seek_phase = SEEK_HEAD;
            r = read_req(pcw_pkg::CAP_PTR_OFFSET);
          end
        end
        SEEK_HEAD: r = chase(it.read_data[7:0]);
        SEEK_ENTRY: begin
          // the hop limit wins over whatever the next pointer says
          if (it.read_data[7:0] == sought_id) begin
            r = walk_done(entry_off, pcw_pkg::OUTCOME_FOUND);
          end else begin
            hops = hops + 6'd1;
            if (hops >= HOP_LIMIT) begin
              r = walk_done(8'h00, pcw_pkg::OUTCOME_HOP_LIMIT);
            end else begin
              r = chase(it.read_data[15:8]);
            end
          end
        end
        default: emits = 1'b0;
      endcase
    end
    if (emits) begin
      walk_results_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic pcw_pkg::item_t rand_item();
    pcw_pkg::item_t it;
    it.cmd = 1'($urandom_range(1));
    it.segment = 16'($urandom_range(16'hFFFF));
    it.bus_number = 8'($urandom_range(8'hFF));
    it.device_number = 5'($urandom_range(5'h1F));
    it.function_number = 3'($urandom_range(3'h7));
    it.wanted_id = 8'($urandom_range(8'hFF));
    it.read_data = $urandom;
    return it;
  endfunction

  task automatic queue_item(input pcw_pkg::item_t it);
    stim_queue.push_back(it);
    items_made++;
  endtask

  task automatic queue_start(input logic [15:0] seg, input logic [7:0] bus,
                             input logic [4:0] dev, input logic [2:0] fn,
                             input logic [7:0] id);
    pcw_pkg::item_t it;
    it = rand_item();
    it.cmd = pcw_pkg::CMD_START;
    it.segment = seg;
    it.bus_number = bus;
    it.device_number = dev;
    it.function_number = fn;
    it.wanted_id = id;
    queue_item(it);
  endtask

  task automatic queue_data(input logic [31:0] dw);
    pcw_pkg::item_t it;
    it = rand_item();
    it.cmd = pcw_pkg::CMD_DATA;
    it.read_data = dw;
    queue_item(it);
  endtask

  // one well-formed search with random content, sometimes cut short
  task automatic queue_walk(input walk_style_t style);
    pcw_pkg::item_t walk[$];
    pcw_pkg::item_t it;
    logic [7:0]     want_id;
    logic [31:0]    dw;
    int             entries;
    int             cut;
    logic           last;
    it = rand_item();
    it.cmd = pcw_pkg::CMD_START;
    want_id = it.wanted_id;
    walk.push_back(it);

    // status half of the dword at 0x04
    dw = $urandom;
    case (style)
      WALK_ABSENT:  dw[31:16] = pcw_pkg::STATUS_ABSENT;
      WALK_NO_LIST: dw[16 + pcw_pkg::STATUS_CAP_BIT] = 1'b0;
      default: begin
        dw[16 + pcw_pkg::STATUS_CAP_BIT] = 1'b1;
        if (dw[31:16] == pcw_pkg::STATUS_ABSENT) begin
          dw[16 + $urandom_range(15)] = 1'b0;
          dw[16 + pcw_pkg::STATUS_CAP_BIT] = 1'b1;
        end
      end
    endcase
    it = rand_item();
    it.cmd = pcw_pkg::CMD_DATA;
    it.read_data = dw;
    walk.push_back(it);

    if (style != WALK_ABSENT && style != WALK_NO_LIST) begin
      // list head
      dw = $urandom;
      dw[7:0] = (style == WALK_EMPTY) ? 8'($urandom_range(8'h3F))
                                      : 8'($urandom_range(8'h40, 8'hFF));
      it.read_data = dw;
      it.segment = 16'($urandom_range(16'hFFFF));
      walk.push_back(it);
      if (style != WALK_EMPTY) begin
        if (style == WALK_HOP_LIMIT) begin
          entries = HOP_LIMIT;
        end else if ($urandom_range(3) == 0) begin
          entries = $urandom_range(1, 24);
        end else begin
          entries = $urandom_range(1, 5);
        end
        for (int i = 0; i < entries; i++) begin
          dw = $urandom;
          last = (i == entries - 1);
          if (last && style == WALK_FOUND) begin
            dw[7:0] = want_id;
          end else if (dw[7:0] == want_id) begin
            dw[7:0] = want_id ^ 8'($urandom_range(1, 255));
          end
          if (last && style == WALK_LIST_END) begin
            dw[15:8] = 8'($urandom_range(8'h3F));
          end else if (!(last && style == WALK_HOP_LIMIT)) begin
            dw[15:8] = 8'($urandom_range(8'h40, 8'hFF));
          end
          it = rand_item();
          it.cmd = pcw_pkg::CMD_DATA;
          it.read_data = dw;
          walk.push_back(it);
        end
      end
    end

    // an early cut leaves the walk busy for the next start to abandon
    cut = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : walk.size();
    for (int i = 0; i < cut && i < walk.size(); i++) begin
      queue_item(walk[i]);
    end
  endtask

  task automatic queue_directed();
    // read data with no search going
    queue_data(32'hFFFF_FFFF);
    // all-ones target, function absent
    queue_start(16'hFFFF, 8'hFF, 5'h1F, 3'h7, 8'hFF);
    queue_data(32'hFFFF_FFFF);
    // all-zeros target, no capability list
    queue_start(16'h0000, 8'h00, 5'h00, 3'h0, 8'h00);
    queue_data(32'h0000_0000);
    // status has every bit but the list bit
    queue_start(16'h8001, 8'h80, 5'h10, 3'h4, 8'h01);
    queue_data(32'hFFEF_FFFF);
    // head just below the list floor
    queue_start(16'h1234, 8'h56, 5'h0A, 3'h2, 8'h11);
    queue_data(32'h0010_0000);
    queue_data(32'hFFFF_FF3F);
    // head at the top of config space, then a hit at the floor
    queue_start(16'h5A5A, 8'hA5, 5'h15, 3'h5, 8'h05);
    queue_data(32'hFFFE_0000);
    queue_data(32'h0000_00FF);
    queue_data(32'h0000_4309);
    queue_data(32'hFFFF_FF05);
    // one entry, then the list ends
    queue_start(16'h00FF, 8'h01, 5'h01, 3'h1, 8'h10);
    queue_data(32'h0010_0000);
    queue_data(32'h0000_0040);
    queue_data(32'h0000_3F11);
    // new start while a search is in progress
    queue_start(16'hBEEF, 8'h12, 5'h03, 3'h6, 8'h09);
    queue_data(32'h0010_0000);
    queue_start(16'hCAFE, 8'h34, 5'h1E, 3'h3, 8'h09);
    queue_data(32'hFFFF_0000);
    // trailing data after the search finished
    queue_data(32'h0010_0040);
  endtask

  task automatic queue_random(input int count);
    pcw_pkg::item_t it;
    walk_style_t    style;
    int             pick;
    int             stop_at;
    stop_at = items_made + count;
    while (items_made < stop_at) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        // raw noise, both commands
        it = rand_item();
        queue_item(it);
      end else begin
        walks_made++;
        pick = $urandom_range(9);
        if (walks_made % 15 == 0) style = WALK_HOP_LIMIT;
        else if (pick == 0) style = WALK_ABSENT;
        else if (pick == 1) style = WALK_NO_LIST;
        else if (pick == 2) style = WALK_EMPTY;
        else if (pick <= 6) style = WALK_FOUND;
        else style = WALK_LIST_END;
        queue_walk(style);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        walk_step({cmd, segment, bus_number, device_number, function_number,
                   wanted_id, read_data});
      end
      if (!in_valid || in_ready) begin
        if (stim_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_item = stim_queue.pop_front();
          in_valid <= 1'b1;
          cmd <= next_item.cmd;
          segment <= next_item.segment;
          bus_number <= next_item.bus_number;
          device_number <= next_item.device_number;
          function_number <= next_item.function_number;
          wanted_id <= next_item.wanted_id;
          read_data <= next_item.read_data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(input string what, input longint got,
                                 input longint exp_val);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, exp_val);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {kind, req_segment, req_bus, req_device, req_function, req_offset,
                found_offset, outcome};
        if (walk_results_due.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(seen.req_offset), 64'(0));
        end else begin
          want = walk_results_due.pop_front();
          if (seen.kind !== want.kind)
            report_mismatch("kind", 64'(seen.kind), 64'(want.kind));
          if (seen.req_segment !== want.req_segment)
            report_mismatch("req_segment", 64'(seen.req_segment), 64'(want.req_segment));
          if (seen.req_bus !== want.req_bus)
            report_mismatch("req_bus", 64'(seen.req_bus), 64'(want.req_bus));
          if (seen.req_device !== want.req_device)
            report_mismatch("req_device", 64'(seen.req_device), 64'(want.req_device));
          if (seen.req_function !== want.req_function)
            report_mismatch("req_function", 64'(seen.req_function),
                            64'(want.req_function));
          if (seen.req_offset !== want.req_offset)
            report_mismatch("req_offset", 64'(seen.req_offset), 64'(want.req_offset));
          if (seen.found_offset !== want.found_offset)
            report_mismatch("found_offset", 64'(seen.found_offset),
                            64'(want.found_offset));
          if (seen.outcome !== want.outcome)
            report_mismatch("outcome", 64'(seen.outcome), 64'(want.outcome));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int send_mix[4];
    int recv_mix[4];
    send_mix = '{0, 82, 0, 33};
    recv_mix = '{0, 0, 82, 33};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_gap_pct = send_mix[p];
      recv_stall_pct = recv_mix[p];
      if (p == 0) begin
        queue_directed();
      end
      queue_random(PHASE_ITEMS);
      while (stim_queue.size() != 0) @(negedge clk);
    end

    // let every transaction drain before judging
    while (in_valid || walk_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pcw_pkg.sv
rtl/core/pcw_step.sv
rtl/core/pci_capability_walker_top.sv
dv/testbench.sv
